/* rtl/pswm_pkg.sv */
// ----------------------------------------------------------------------------
// pswm_pkg
// Shared types, constants and the amplitude table of the square-wave mixer.
// ----------------------------------------------------------------------------
package pswm_pkg;

  // voice bank size and sample rate
  localparam int MAX_VOICES   = 8;
  localparam int VOICE_IDX_W  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int COUNT_W      = $clog2(MAX_VOICES + 1);
  localparam int SAMPLE_RATE  = 48000;

  // field widths
  localparam int IDX_W   = 8;
  localparam int FREQ_W  = 16;
  localparam int VOL_W   = 8;
  localparam int PHASE_W = 16;
  localparam int ACC_W   = PHASE_W + 1;
  localparam int SMP_W   = 16;
  localparam int CFG_W   = 4;
  localparam int TDATA_IN_W  = IDX_W + FREQ_W + VOL_W;

  // amplitude scaling, 0.2 of full scale at full volume
  localparam int AMP_NUM   = 6554;
  localparam int AMP_DEN   = 255;
  localparam int AMP_W     = 13;
  localparam int CLAMP_MAX = 32767;
  localparam int SUM_W     = $clog2(MAX_VOICES * AMP_NUM + 1) + 1;

  // item kinds carried in tuser
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  // configuration register indexes
  localparam logic REG_VOICES = 1'b0;
  localparam logic REG_RUN    = 1'b1;

  // one voice as read from the bank
  typedef struct packed {
    logic [FREQ_W-1:0]  freq;
    logic [VOL_W-1:0]   volume;
    logic [PHASE_W-1:0] phase;
  } voice_t;

  // amplitude per volume code
  typedef logic [AMP_W-1:0] amp_table_t [2**VOL_W];

  function automatic amp_table_t build_amp_table();
    amp_table_t t;
    for (int i = 0; i < 2**VOL_W; i++) begin
      t[i] = AMP_W'((i * AMP_NUM) / AMP_DEN);
    end
    return t;
  endfunction

  localparam amp_table_t AMP_TABLE = build_amp_table();

endpackage

/* rtl/pswm_voice_bank.sv */
// ----------------------------------------------------------------------------
// pswm_voice_bank
// Per-voice frequency, volume and phase registers with one read port.
// ----------------------------------------------------------------------------
module pswm_voice_bank (
  input  logic                               clk,
  input  logic                               rst,
  // voice parameter write
  input  logic                               set_en,
  input  logic [pswm_pkg::VOICE_IDX_W-1:0]   set_idx,
  input  logic [pswm_pkg::FREQ_W-1:0]        set_freq,
  input  logic [pswm_pkg::VOL_W-1:0]         set_vol,
  // phase write-back
  input  logic                               ph_en,
  input  logic [pswm_pkg::VOICE_IDX_W-1:0]   ph_idx,
  input  logic [pswm_pkg::PHASE_W-1:0]       ph_val,
  // read port
  input  logic [pswm_pkg::VOICE_IDX_W-1:0]   rd_idx,
  output pswm_pkg::voice_t                   rd
);

  logic [pswm_pkg::FREQ_W-1:0]  freq   [pswm_pkg::MAX_VOICES];
  logic [pswm_pkg::VOL_W-1:0]   volume [pswm_pkg::MAX_VOICES];
  logic [pswm_pkg::PHASE_W-1:0] phase  [pswm_pkg::MAX_VOICES];

  // storage, all cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pswm_pkg::MAX_VOICES; i++) begin
        freq[i]   <= '0;
        volume[i] <= '0;
        phase[i]  <= '0;
      end
    end else begin
      if (set_en) begin
        freq[set_idx]   <= set_freq;
        volume[set_idx] <= set_vol;
      end
      if (ph_en) begin
        phase[ph_idx] <= ph_val;
      end
    end
  end

  // read mux
  always_comb begin
    rd.freq   = freq[rd_idx];
    rd.volume = volume[rd_idx];
    rd.phase  = phase[rd_idx];
  end

endmodule

/* rtl/polyphonic_square_wave_mixer_core.sv */
// ----------------------------------------------------------------------------
// polyphonic_square_wave_mixer_core
// Multi-voice square-wave synthesizer with a phase accumulator per voice.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transaction. tuser = 0 is a sample tick,
//   tuser = 1 sets one voice's frequency and volume from tdata. A set is
//   dropped when the voice index is at or above the active voice count.
//   m_axis returns one clamped Q1.15 sample for every tick, none for sets.
//   cfg_we/cfg_index/cfg_wdata write the voice count (0) and the run flag
//   (1) while the block is idle.
// Timing:
//   A set is taken in the idle state and leaves the sequencer idle. A tick
//   walks the active voices one at a time: a silent voice is skipped in the
//   mix state, a sounding voice passes through the mix state and then the
//   shared phase-wrap subtractor, which subtracts the sample rate until the
//   phase is below it. When audio is stopped a tick goes straight to the
//   finish state. s_axis_tready is high only while the sequencer is idle.
// Reset and stalls:
//   rst clears all voices, sets the voice count to 1 and stops audio. A
//   stalled m_axis holds its sample; the sequencer waits at the end of the
//   next tick until the output register frees, and takes no items meanwhile.
// ----------------------------------------------------------------------------
module polyphonic_square_wave_mixer_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // input item: voice_sel[7:0], freq_hz[23:8], volume[31:24]
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [pswm_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
  // item kind: func[0]
  input  logic                                 s_axis_tuser,
  // result item: sample[15:0]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pswm_pkg::SMP_W-1:0]           m_axis_tdata,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [pswm_pkg::CFG_W-1:0]           cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_WRAP,
    ST_FINISH
  } state_t;

  localparam logic [pswm_pkg::ACC_W-1:0] SR_ACC = pswm_pkg::ACC_W'(pswm_pkg::SAMPLE_RATE);
  localparam logic signed [pswm_pkg::SUM_W-1:0] SUM_MAX =
    pswm_pkg::SUM_W'(pswm_pkg::CLAMP_MAX);
  localparam logic signed [pswm_pkg::SUM_W-1:0] SUM_MIN = -SUM_MAX;

  state_t                                state;
  logic [pswm_pkg::CFG_W-1:0]            num_voices;
  logic                                  run_en;
  logic [pswm_pkg::VOICE_IDX_W-1:0]      cur;
  logic signed [pswm_pkg::SUM_W-1:0]     sum;
  logic [pswm_pkg::ACC_W-1:0]            acc;

  logic [pswm_pkg::COUNT_W-1:0]          n_active;
  logic                                  in_accept;
  logic                                  set_en;
  logic                                  last_voice;
  logic                                  voice_silent;
  logic                                  phase_high;
  logic signed [pswm_pkg::SUM_W-1:0]     amp;
  logic                                  ph_en;
  logic                                  out_load;
  logic [pswm_pkg::SMP_W-1:0]            clamped;
  pswm_pkg::voice_t                      rd;

  logic [pswm_pkg::IDX_W-1:0]            in_idx;
  logic [pswm_pkg::FREQ_W-1:0]           in_freq;
  logic [pswm_pkg::VOL_W-1:0]            in_vol;

  assign in_idx  = s_axis_tdata[pswm_pkg::IDX_W-1:0];
  assign in_freq = s_axis_tdata[pswm_pkg::IDX_W +: pswm_pkg::FREQ_W];
  assign in_vol  = s_axis_tdata[pswm_pkg::IDX_W + pswm_pkg::FREQ_W +: pswm_pkg::VOL_W];

  // effective voice count, zero acts as one, values above MAX_VOICES act as MAX_VOICES
  always_comb begin
    if (num_voices == '0) begin
      n_active = pswm_pkg::COUNT_W'(1);
    end else if (int'(num_voices) > pswm_pkg::MAX_VOICES) begin
      n_active = pswm_pkg::COUNT_W'(pswm_pkg::MAX_VOICES);
    end else begin
      n_active = pswm_pkg::COUNT_W'(num_voices);
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign set_en        = in_accept && (s_axis_tuser == pswm_pkg::FUNC_SET) &&
                         (in_idx < pswm_pkg::IDX_W'(n_active));

  // per-voice decode
  assign last_voice   = ((pswm_pkg::COUNT_W'(cur) + pswm_pkg::COUNT_W'(1)) == n_active);
  assign voice_silent = (rd.freq == '0) || (rd.volume == '0);
  assign phase_high   = ({rd.phase, 1'b0} < SR_ACC);
  assign amp          = pswm_pkg::SUM_W'(pswm_pkg::AMP_TABLE[rd.volume]);
  assign ph_en        = (state == ST_WRAP) && (acc < SR_ACC);
  assign out_load     = (state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready);

  // output clamp
  always_comb begin
    priority if (sum > SUM_MAX) begin
      clamped = pswm_pkg::SMP_W'(SUM_MAX);
    end else if (sum < SUM_MIN) begin
      clamped = pswm_pkg::SMP_W'(SUM_MIN);
    end else begin
      clamped = sum[pswm_pkg::SMP_W-1:0];
    end
  end

  pswm_voice_bank u_bank (
    .clk      (clk),
    .rst      (rst),
    .set_en   (set_en),
    .set_idx  (in_idx[pswm_pkg::VOICE_IDX_W-1:0]),
    .set_freq (in_freq),
    .set_vol  (in_vol),
    .ph_en    (ph_en),
    .ph_idx   (cur),
    .ph_val   (acc[pswm_pkg::PHASE_W-1:0]),
    .rd_idx   (cur),
    .rd       (rd)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_voices <= pswm_pkg::CFG_W'(1);
      run_en     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pswm_pkg::REG_VOICES: num_voices <= cfg_wdata;
        pswm_pkg::REG_RUN:    run_en     <= cfg_wdata[0];
        default:              num_voices <= num_voices;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      cur           <= '0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept && (s_axis_tuser == pswm_pkg::FUNC_TICK)) begin
            sum <= '0;
            cur <= '0;
            state <= run_en ? ST_MIX : ST_FINISH;
          end
        end
        ST_MIX: begin
          if (voice_silent) begin
            if (last_voice) begin
              state <= ST_FINISH;
            end else begin
              cur <= cur + pswm_pkg::VOICE_IDX_W'(1);
            end
          end else begin
            sum   <= phase_high ? (sum + amp) : (sum - amp);
            acc   <= pswm_pkg::ACC_W'(rd.phase) + pswm_pkg::ACC_W'(rd.freq);
            state <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (acc >= SR_ACC) begin
            acc <= acc - SR_ACC;
          end else if (last_voice) begin
            state <= ST_FINISH;
          end else begin
            cur   <= cur + pswm_pkg::VOICE_IDX_W'(1);
            state <= ST_MIX;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            m_axis_tdata <= clamped;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // written-back phase stays below the sample rate
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    ph_en |-> (acc < SR_ACC))
    else $error("phase write-back out of range");

  // the voice walk never passes the active count
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MIX || state == ST_WRAP) |-> (pswm_pkg::COUNT_W'(cur) < n_active))
    else $error("voice index beyond active count");

  // a voice set never raises a result
  a_set_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tuser == pswm_pkg::FUNC_SET) |=> !$rose(m_axis_tvalid))
    else $error("result after voice set");

  // results stay inside the clamp range
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata != {1'b1, {(pswm_pkg::SMP_W-1){1'b0}}}))
    else $error("sample outside clamp range");

  // wrap subtraction is entered only from a sounding voice
  a_wrap_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MIX && voice_silent) |=> (state != ST_WRAP))
    else $error("wrap entered for silent voice");

endmodule
